/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/tals_pkg.sv */
// ----------------------------------------------------------------------------
// tals_pkg
// types, constants and helpers of the trackball axis locked stepper
// ----------------------------------------------------------------------------
`default_nettype none

package tals_pkg;

   localparam int MOTION_BITS = 8;
   localparam int ACCUM_BITS  = 16;
   localparam int REG_BITS    = 14;
   localparam int WIDE_BITS   = ((ACCUM_BITS > REG_BITS) ? ACCUM_BITS : REG_BITS) + 2;

   localparam logic [REG_BITS-1:0] STEP_RESET = REG_BITS'(40);
   localparam logic [REG_BITS-1:0] LOCK_RESET = REG_BITS'(20);

   typedef logic signed [MOTION_BITS-1:0] motion_type;
   typedef logic signed [ACCUM_BITS-1:0]  accum_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic [REG_BITS-1:0]           thresh_type;

   typedef logic [1:0] axis_type;
   localparam axis_type AX_NONE  = 2'd0;
   localparam axis_type AX_HORIZ = 2'd1;
   localparam axis_type AX_VERT  = 2'd2;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_PASS = 2'd0;

   typedef logic [3:0] action_type;
   localparam action_type ACT_NONE        = 4'd0;
   localparam action_type ACT_RIGHT       = 4'd1;
   localparam action_type ACT_LEFT        = 4'd2;
   localparam action_type ACT_DOWN        = 4'd3;
   localparam action_type ACT_UP          = 4'd4;
   localparam action_type ACT_VOL_UP      = 4'd5;
   localparam action_type ACT_VOL_DOWN    = 4'd6;
   localparam action_type ACT_BRIGHT_DOWN = 4'd7;
   localparam action_type ACT_BRIGHT_UP   = 4'd8;
   localparam action_type ACT_ZOOM_IN     = 4'd9;
   localparam action_type ACT_ZOOM_OUT    = 4'd10;

   typedef logic [0:0] reg_index_type;
   localparam reg_index_type REG_STEP = 1'd0;
   localparam reg_index_type REG_LOCK = 1'd1;

   localparam wide_type ACC_MAX = {{(WIDE_BITS-ACCUM_BITS+1){1'b0}}, {(ACCUM_BITS-1){1'b1}}};
   localparam wide_type ACC_MIN = ~ACC_MAX;

   function automatic accum_type sat_acc(input wide_type v);
      accum_type r;
      if (v > ACC_MAX) begin
         r = ACC_MAX[ACCUM_BITS-1:0];
      end else if (v < ACC_MIN) begin
         r = ACC_MIN[ACCUM_BITS-1:0];
      end else begin
         r = v[ACCUM_BITS-1:0];
      end
      return r;
   endfunction

   function automatic action_type step_code(input axis_type axis, input motion_type dx,
                                            input motion_type dy, input logic nav,
                                            input logic bright, input logic zoom);
      action_type a;
      a = ACT_NONE;
      if (axis == AX_HORIZ) begin
         if (dx > 0) begin
            a = nav ? ACT_RIGHT : ACT_VOL_UP;
         end else if (dx < 0) begin
            a = nav ? ACT_LEFT : ACT_VOL_DOWN;
         end
      end else begin
         if (dy > 0) begin
            a = bright ? ACT_BRIGHT_DOWN : zoom ? ACT_ZOOM_IN : nav ? ACT_DOWN : ACT_VOL_DOWN;
         end else if (dy < 0) begin
            a = bright ? ACT_BRIGHT_UP : zoom ? ACT_ZOOM_OUT : nav ? ACT_UP : ACT_VOL_UP;
         end
      end
      return a;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/trackball_axis_locked_stepper.sv */
// ----------------------------------------------------------------------------
// trackball_axis_locked_stepper
// a word is taken into the input register, then moves on into the result register
// one word per cycle unless rsp_stall holds it; the state update sits between the two
// reset: synchronous, clears sums, step accumulator, axis lock and both valid flags
// reset: step threshold returns to 40 and lock threshold to 20
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module trackball_axis_locked_stepper (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  signed [tals_pkg::MOTION_BITS-1:0] req_dx,
   input  wire  signed [tals_pkg::MOTION_BITS-1:0] req_dy,
   input  wire  [7:0]                            req_buttons,
   input  wire  [1:0]                            req_mode,
   input  wire                                   req_bright_mod,
   input  wire                                   req_zoom_mod,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [tals_pkg::MOTION_BITS-1:0] rsp_out_x,
   output logic signed [tals_pkg::MOTION_BITS-1:0] rsp_out_y,
   output logic [7:0]                            rsp_out_buttons,
   output logic [3:0]                            rsp_step_action,
   input  wire                                   csr_psel,
   input  wire                                   csr_penable,
   input  wire                                   csr_pwrite,
   input  wire  [2:0]                            csr_paddr,
   input  wire  [31:0]                           csr_pwdata,
   output logic [31:0]                           csr_prdata,
   output logic                                  csr_pready
);

   // configuration
   tals_pkg::thresh_type step_thr_ff;
   tals_pkg::thresh_type lock_thr_ff;
   tals_pkg::reg_index_type csr_index;
   logic csr_write;

   // input stage
   logic                    in_valid_ff;
   tals_pkg::motion_type    dx_ff;
   tals_pkg::motion_type    dy_ff;
   logic [7:0]              buttons_ff;
   tals_pkg::mode_type      mode_ff;
   logic                    bright_ff;
   logic                    zoom_ff;

   // result stage
   logic                    out_valid_ff;
   tals_pkg::motion_type    out_x_ff;
   tals_pkg::motion_type    out_y_ff;
   logic [7:0]              out_buttons_ff;
   tals_pkg::action_type    action_ff;

   // stepping state
   tals_pkg::accum_type     horiz_sum_ff, horiz_sum_in;
   tals_pkg::accum_type     vert_sum_ff, vert_sum_in;
   tals_pkg::accum_type     step_accum_ff, step_accum_in;
   tals_pkg::axis_type      locked_axis_ff, locked_axis_in;
   tals_pkg::action_type    action_in;

   logic advance;
   logic req_take;

   tals_pkg::wide_type lock_w, step_w, bias_w, dx_w, dy_w, move_w;
   tals_pkg::accum_type h1, v1, acc1, acc2;
   tals_pkg::wide_type h1_w, v1_w, acc2_w;
   tals_pkg::axis_type axis1;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_index)
         tals_pkg::REG_STEP: csr_prdata = 32'(step_thr_ff);
         tals_pkg::REG_LOCK: csr_prdata = 32'(lock_thr_ff);
         default:            csr_prdata = 32'd0;
      endcase
   end

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_x       = out_x_ff;
   assign rsp_out_y       = out_y_ff;
   assign rsp_out_buttons = out_buttons_ff;
   assign rsp_step_action = action_ff;

   always_comb begin
      lock_w = signed'(tals_pkg::WIDE_BITS'(lock_thr_ff));
      step_w = signed'(tals_pkg::WIDE_BITS'(step_thr_ff));
      bias_w = signed'(tals_pkg::WIDE_BITS'(lock_thr_ff >> 1));
      dx_w   = tals_pkg::WIDE_BITS'(dx_ff);
      dy_w   = tals_pkg::WIDE_BITS'(dy_ff);

      h1 = tals_pkg::sat_acc(tals_pkg::WIDE_BITS'(horiz_sum_ff) + dx_w);
      v1 = tals_pkg::sat_acc(tals_pkg::WIDE_BITS'(vert_sum_ff) + dy_w);
      h1_w = tals_pkg::WIDE_BITS'(h1);
      v1_w = tals_pkg::WIDE_BITS'(v1);

      horiz_sum_in = h1;
      vert_sum_in  = v1;
      axis1        = locked_axis_ff;
      acc1         = step_accum_ff;

      // axis lock, horizontal checked first
      if (h1_w > lock_w || h1_w < -lock_w) begin
         if (locked_axis_ff != tals_pkg::AX_HORIZ) begin
            acc1 = '0;
         end
         axis1        = tals_pkg::AX_HORIZ;
         vert_sum_in  = '0;
         horiz_sum_in = tals_pkg::sat_acc(bias_w);
      end else if (v1_w > lock_w || v1_w < -lock_w) begin
         if (locked_axis_ff != tals_pkg::AX_VERT) begin
            acc1 = '0;
         end
         axis1        = tals_pkg::AX_VERT;
         horiz_sum_in = '0;
         vert_sum_in  = tals_pkg::sat_acc(bias_w);
      end

      move_w        = (axis1 == tals_pkg::AX_HORIZ) ? dx_w : dy_w;
      acc2          = tals_pkg::sat_acc(tals_pkg::WIDE_BITS'(acc1) + move_w);
      acc2_w        = tals_pkg::WIDE_BITS'(acc2);
      locked_axis_in = axis1;
      step_accum_in = acc1;
      action_in     = tals_pkg::ACT_NONE;

      if (axis1 == tals_pkg::AX_HORIZ || axis1 == tals_pkg::AX_VERT) begin
         step_accum_in = acc2;
         if (acc2_w >= step_w || acc2_w <= -step_w) begin
            action_in = tals_pkg::step_code(axis1, dx_ff, dy_ff, mode_ff[1], bright_ff,
                                            zoom_ff);
            if (acc2_w < 0) begin
               step_accum_in = tals_pkg::sat_acc(acc2_w + step_w);
            end else begin
               step_accum_in = tals_pkg::sat_acc(acc2_w - step_w);
            end
            horiz_sum_in = '0;
            vert_sum_in  = '0;
            if (axis1 == tals_pkg::AX_HORIZ) begin
               horiz_sum_in = tals_pkg::sat_acc(bias_w);
            end else begin
               vert_sum_in = tals_pkg::sat_acc(bias_w);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_thr_ff <= tals_pkg::STEP_RESET;
         lock_thr_ff <= tals_pkg::LOCK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            tals_pkg::REG_STEP: step_thr_ff <= csr_pwdata[tals_pkg::REG_BITS-1:0];
            tals_pkg::REG_LOCK: lock_thr_ff <= csr_pwdata[tals_pkg::REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= req_take || (in_valid_ff && !advance);
      end
      if (req_take) begin
         dx_ff      <= req_dx;
         dy_ff      <= req_dy;
         buttons_ff <= req_buttons;
         mode_ff    <= req_mode;
         bright_ff  <= req_bright_mod;
         zoom_ff    <= req_zoom_mod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= advance || (out_valid_ff && rsp_stall);
      end
      if (advance) begin
         out_buttons_ff <= buttons_ff;
         if (mode_ff == tals_pkg::MODE_PASS) begin
            out_x_ff  <= dx_ff;
            out_y_ff  <= dy_ff;
            action_ff <= tals_pkg::ACT_NONE;
         end else begin
            out_x_ff  <= '0;
            out_y_ff  <= '0;
            action_ff <= action_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_sum_ff   <= '0;
         vert_sum_ff    <= '0;
         step_accum_ff  <= '0;
         locked_axis_ff <= tals_pkg::AX_NONE;
      end else if (advance && mode_ff != tals_pkg::MODE_PASS) begin
         horiz_sum_ff   <= horiz_sum_in;
         vert_sum_ff    <= vert_sum_in;
         step_accum_ff  <= step_accum_in;
         locked_axis_ff <= locked_axis_in;
      end
   end

   `ASSERT_IMPL(a_stall_only_when_full, clock, reset, req_stall, out_valid_ff && rsp_stall)
   `ASSERT_IMPL(a_step_has_no_motion, clock, reset, rsp_valid && rsp_step_action != tals_pkg::ACT_NONE, rsp_out_x == 0 && rsp_out_y == 0)
   `ASSERT_NEXT(a_state_holds_when_idle, clock, reset, !advance, $stable(step_accum_ff) && $stable(locked_axis_ff))
   `ASSERT_IMPL(a_no_action_unlocked, clock, reset, locked_axis_ff == tals_pkg::AX_NONE, step_accum_ff == 0)

endmodule

`default_nettype wire

/* dv/trackball_axis_locked_stepper_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trackball axis locked stepper checker
// watches the report, result and register ports, keeps a private model of
// the axis lock and step accumulator, and compares every result word against
// the oldest predicted one
// ----------------------------------------------------------------------------

module trackball_axis_locked_stepper_checker
   import tals_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_stall,
   input  wire signed [MOTION_BITS-1:0] req_dx,
   input  wire signed [MOTION_BITS-1:0] req_dy,
   input  wire [7:0]             req_buttons,
   input  wire [1:0]             req_mode,
   input  wire                   req_bright_mod,
   input  wire                   req_zoom_mod,
   input  wire                   rsp_valid,
   input  wire                   rsp_stall,
   input  wire signed [MOTION_BITS-1:0] rsp_out_x,
   input  wire signed [MOTION_BITS-1:0] rsp_out_y,
   input  wire [7:0]             rsp_out_buttons,
   input  wire [3:0]             rsp_step_action,
   input  wire                   csr_psel,
   input  wire                   csr_penable,
   input  wire                   csr_pwrite,
   input  wire                   csr_pready,
   input  wire [2:0]             csr_paddr,
   input  wire [31:0]            csr_pwdata,
   output int                    fail_count,
   output int                    results_pending,
   output int                    results_checked,
   output int                    steps_checked
);

   localparam int ACC_HI = (1 << (ACCUM_BITS - 1)) - 1;
   localparam int ACC_LO = -ACC_HI - 1;

   typedef struct packed {
      motion_type out_x;
      motion_type out_y;
      logic [7:0] out_buttons;
      action_type step_action;
   } report_out_type;

   report_out_type predicted_reports[$];

   int       step_thr;
   int       lock_thr;
   int       h_sum;
   int       v_sum;
   int       step_acc;
   axis_type lock_axis;
   int       mismatches;
   int       checked;
   int       steps;

   function automatic int clamp_acc(input int v);
      int r;
      r = v;
      if (v > ACC_HI) r = ACC_HI;
      else if (v < ACC_LO) r = ACC_LO;
      return r;
   endfunction

   function automatic int magn(input int v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic advance_stepper(input motion_type dx, input motion_type dy,
                                  input logic [7:0] btn, input mode_type md,
                                  input logic bright, input logic zoom);
      report_out_type r;
      int          x;
      int          y;
      int          bias;
      logic        nav;
      x = dx;
      y = dy;
      nav = md[1];
      bias = lock_thr / 2;
      r.out_buttons = btn;
      r.step_action = ACT_NONE;
      r.out_x = '0;
      r.out_y = '0;
      if (md == MODE_PASS) begin
         r.out_x = dx;
         r.out_y = dy;
      end else begin
         h_sum = clamp_acc(h_sum + x);
         v_sum = clamp_acc(v_sum + y);
         // horizontal axis is tested first
         if (magn(h_sum) > lock_thr) begin
            if (lock_axis != AX_HORIZ) step_acc = 0;
            lock_axis = AX_HORIZ;
            v_sum = 0;
            h_sum = clamp_acc(bias);
         end else if (magn(v_sum) > lock_thr) begin
            if (lock_axis != AX_VERT) step_acc = 0;
            lock_axis = AX_VERT;
            h_sum = 0;
            v_sum = clamp_acc(bias);
         end
         if (lock_axis == AX_HORIZ || lock_axis == AX_VERT) begin
            step_acc = clamp_acc(step_acc + ((lock_axis == AX_HORIZ) ? x : y));
            if (magn(step_acc) >= step_thr) begin
               if (lock_axis == AX_HORIZ) begin
                  if (x > 0) r.step_action = nav ? ACT_RIGHT : ACT_VOL_UP;
                  else if (x < 0) r.step_action = nav ? ACT_LEFT : ACT_VOL_DOWN;
               end else begin
                  if (y > 0) begin
                     r.step_action = bright ? ACT_BRIGHT_DOWN : zoom ? ACT_ZOOM_IN :
                                     nav ? ACT_DOWN : ACT_VOL_DOWN;
                  end else if (y < 0) begin
                     r.step_action = bright ? ACT_BRIGHT_UP : zoom ? ACT_ZOOM_OUT :
                                     nav ? ACT_UP : ACT_VOL_UP;
                  end
               end
               if (step_acc < 0) step_acc = clamp_acc(step_acc + step_thr);
               else step_acc = clamp_acc(step_acc - step_thr);
               h_sum = 0;
               v_sum = 0;
               if (lock_axis == AX_HORIZ) h_sum = clamp_acc(bias);
               else v_sum = clamp_acc(bias);
            end
         end
      end
      predicted_reports.push_back(r);
   endtask

   always @(posedge clock) begin
      report_out_type want;
      if (reset) begin
         step_thr = STEP_RESET;
         lock_thr = LOCK_RESET;
         h_sum = 0;
         v_sum = 0;
         step_acc = 0;
         lock_axis = AX_NONE;
         mismatches = 0;
         checked = 0;
         steps = 0;
         predicted_reports.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (reg_index_type'(csr_paddr[2]) == REG_STEP) step_thr = csr_pwdata[REG_BITS-1:0];
            else if (reg_index_type'(csr_paddr[2]) == REG_LOCK) lock_thr = csr_pwdata[REG_BITS-1:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result word: x=%0d y=%0d buttons=%02h action=%0d",
                           rsp_out_x, rsp_out_y, rsp_out_buttons, rsp_step_action);
            end else begin
               want = predicted_reports.pop_front();
               checked++;
               if (want.step_action != ACT_NONE) steps++;
               if (rsp_out_x !== want.out_x || rsp_out_y !== want.out_y ||
                   rsp_out_buttons !== want.out_buttons ||
                   rsp_step_action !== want.step_action) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("word %0d: expected x=%0d y=%0d buttons=%02h action=%0d, %s",
                              checked, want.out_x, want.out_y, want.out_buttons,
                              want.step_action,
                              $sformatf("got x=%0d y=%0d buttons=%02h action=%0d",
                                        rsp_out_x, rsp_out_y, rsp_out_buttons,
                                        rsp_step_action));
               end
            end
         end
         if (req_valid && !req_stall)
            advance_stepper(req_dx, req_dy, req_buttons, req_mode, req_bright_mod,
                            req_zoom_mod);
      end
      fail_count <= mismatches;
      results_pending <= predicted_reports.size();
      results_checked <= checked;
      steps_checked <= steps;
   end

endmodule

/* dv/tb_trackball_axis_locked_stepper.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trackball_axis_locked_stepper
// drives motion reports and threshold writes into the stepper with random
// gaps and result back-pressure; the checker beside the block predicts and
// compares, and this module gives the verdict
// ----------------------------------------------------------------------------

module tb_trackball_axis_locked_stepper;
   import tals_pkg::*;

   localparam mode_type MODE_BROWSE = 2'd1;
   localparam mode_type MODE_NAV    = 2'd2;
   localparam mode_type MODE_BOTH   = 2'd3;
   localparam int IDLE_PCT    = 25;
   localparam int HOLD_CYCLES = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   motion_type req_dx = '0;
   motion_type req_dy = '0;
   logic [7:0] req_buttons = '0;
   mode_type   req_mode = MODE_PASS;
   logic       req_bright_mod = 1'b0;
   logic       req_zoom_mod = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   motion_type rsp_out_x;
   motion_type rsp_out_y;
   logic [7:0] rsp_out_buttons;
   logic [3:0] rsp_step_action;
   logic       csr_psel = 1'b0;
   logic       csr_penable = 1'b0;
   logic       csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic       csr_pready;

   int fail_count;
   int results_pending;
   int results_checked;
   int steps_checked;
   int words_sent = 0;
   int settings_used = 1;
   bit no_idle = 1'b0;
   bit hold_off_req = 1'b0;
   bit hold_done = 1'b0;

   always #5 clock = ~clock;

   trackball_axis_locked_stepper uut (.*);

   trackball_axis_locked_stepper_checker checker_i (
      .clock, .reset,
      .req_valid, .req_stall, .req_dx, .req_dy, .req_buttons, .req_mode,
      .req_bright_mod, .req_zoom_mod,
      .rsp_valid, .rsp_stall, .rsp_out_x, .rsp_out_y, .rsp_out_buttons, .rsp_step_action,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .fail_count, .results_pending, .results_checked, .steps_checked
   );

   // result side back-pressure, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   task automatic send_report(input motion_type dx, input motion_type dy,
                              input logic [7:0] btn, input mode_type md,
                              input logic bright, input logic zoom);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_dx <= dx;
      req_dy <= dy;
      req_buttons <= btn;
      req_mode <= md;
      req_bright_mod <= bright;
      req_zoom_mod <= zoom;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_thresholds(input int step_val, input int lock_val);
      drain_results;
      write_reg(REG_STEP, step_val);
      write_reg(REG_LOCK, lock_val);
      settings_used++;
   endtask

   // one swipe along a dominant axis with small cross-axis jitter, some noise words
   task automatic send_gesture(inout int left);
      int       len;
      int       i;
      int       sgn;
      int       span;
      int       main_v;
      int       side_v;
      int       pick;
      logic     horiz;
      logic     bright;
      logic     zoom;
      logic [7:0] btn;
      mode_type md;
      len = $urandom_range(3, 14);
      if (len > left) len = left;
      horiz = $urandom_range(1);
      sgn = $urandom_range(1) ? 1 : -1;
      bright = ($urandom_range(3) == 0);
      zoom = ($urandom_range(2) == 0);
      btn = 8'($urandom);
      case ($urandom_range(2))
         0: begin
            span = 3;
         end
         1: begin
            span = 24;
         end
         default: begin
            span = 127;
         end
      endcase
      pick = $urandom_range(99);
      if (pick < 10) md = MODE_PASS;
      else if (pick < 45) md = MODE_BROWSE;
      else if (pick < 85) md = MODE_NAV;
      else md = MODE_BOTH;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(9) == 0) begin
            send_report(motion_type'($urandom), motion_type'($urandom), 8'($urandom),
                        mode_type'($urandom_range(3)), 1'($urandom_range(1)),
                        1'($urandom_range(1)));
         end else begin
            main_v = $urandom_range(span);
            if ($urandom_range(7) == 0) main_v = -main_v;
            main_v = main_v * sgn;
            side_v = int'($urandom_range(6)) - 3;
            if (horiz)
               send_report(motion_type'(main_v), motion_type'(side_v), btn, md, bright, zoom);
            else
               send_report(motion_type'(side_v), motion_type'(main_v), btn, md, bright, zoom);
         end
      end
      left -= len;
   endtask

   task automatic random_words(input int count);
      int left;
      left = count;
      while (left > 0) send_gesture(left);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: pass-through extremes, lock order, every action code
      send_report(-128, 127, 8'hFF, MODE_PASS, 1'b1, 1'b1);
      send_report(127, -128, 8'h00, MODE_PASS, 1'b0, 1'b0);
      send_report(5, -5, 8'hA5, MODE_BROWSE, 1'b0, 1'b0);
      send_report(100, 100, 8'h5A, MODE_BOTH, 1'b0, 1'b0);
      send_report(-128, 0, 8'h01, MODE_NAV, 1'b0, 1'b0);
      send_report(-60, 0, 8'h02, MODE_BROWSE, 1'b0, 1'b0);
      send_report(90, 0, 8'h04, MODE_BROWSE, 1'b0, 1'b0);
      send_report(0, 127, 8'h08, MODE_NAV, 1'b0, 1'b0);
      send_report(0, -128, 8'h10, MODE_NAV, 1'b0, 1'b0);
      send_report(0, 100, 8'h20, MODE_BROWSE, 1'b0, 1'b0);
      send_report(0, -100, 8'h40, MODE_BROWSE, 1'b0, 1'b0);
      send_report(0, 100, 8'h80, MODE_BROWSE, 1'b1, 1'b0);
      send_report(0, -100, 8'h7F, MODE_BROWSE, 1'b1, 1'b0);
      send_report(0, 100, 8'hFE, MODE_NAV, 1'b0, 1'b1);
      send_report(0, -100, 8'h3C, MODE_NAV, 1'b0, 1'b1);
      send_report(0, 100, 8'hC3, MODE_BOTH, 1'b1, 1'b1);
      send_report(0, 30, 8'h11, MODE_NAV, 1'b0, 1'b0);
      send_report(-128, -128, 8'h22, MODE_BOTH, 1'b0, 1'b0);
      send_report(127, 127, 8'h44, MODE_NAV, 1'b1, 1'b0);
      send_report(0, 0, 8'h88, MODE_NAV, 1'b0, 1'b0);

      // receiver holds off while reports keep coming
      set_thresholds(40, 20);
      hold_off_req = 1'b1;
      random_words(250);

      set_thresholds(1, 2);
      random_words(150);

      set_thresholds(16383, 16383);
      random_words(40);

      // zero step threshold: every locked report steps, zero motion gives no action
      set_thresholds(0, 2);
      send_report(0, 100, 8'h55, MODE_NAV, 1'b0, 1'b0);
      send_report(0, 0, 8'hAA, MODE_NAV, 1'b0, 1'b0);
      send_report(0, -1, 8'h0F, MODE_BROWSE, 1'b0, 1'b0);
      random_words(80);

      set_thresholds(7, 12);
      no_idle = 1'b1;
      random_words(200);
      no_idle = 1'b0;

      set_thresholds(16383, 2);
      random_words(60);

      set_thresholds(100, 60);
      random_words(200);

      set_thresholds(3, 16383);
      random_words(30);

      drain_results;
      $display("covered %0d reports over %0d threshold settings, %0d results with steps",
               words_sent, settings_used, steps_checked);
      $display("%0d result words compared, %0d mismatches", results_checked, fail_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout waiting for the stepper");
      $display("FAILED: results differ");
      $finish;
   end

endmodule
